>>> design/ssr_pkg.sv
// Shared types and constants for the sorted segment reduce block.
// Holds the reduction codes, the segment id width and the control/status structs.
// No dependencies.
`default_nettype none

package ssr_pkg;

  localparam int VALUE_W  = 32;
  localparam int ACC_W    = 64;
  localparam int COUNT_W  = 32;
  localparam int ID_W     = 16;
  localparam int SEG_BITS = 16;   // low id bits that take part in the run compare
  localparam int MODE_W   = 3;

  localparam logic [ID_W-1:0] SEG_MASK = ID_W'((64'd1 << SEG_BITS) - 64'd1);

  // Divider for the mean: one quotient bit per step over the whole 64-bit sum.
  localparam int DIV_STEPS  = ACC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [MODE_W-1:0] MODE_MAX  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MIN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUM  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MEAN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PROD = 3'd4;

  typedef struct packed {
    logic latch;      // capture the accepted item
    logic fold;       // fold the item into the open run
    logic start;      // open a new run with the item
    logic clear;      // close the run and zero the state
    logic div_init;   // load the divider for a mean report
    logic div_step;   // advance the divider by one bit
    logic out_load;   // load the result register
    logic out_last;   // flag carried with the loaded result
  } ssr_cmd_t;

  typedef struct packed {
    logic match;      // item id equals the open run's id
    logic run_open;
    logic item_last;
    logic is_mean;
    logic div_done;
    logic out_free;   // result register can take a new result this cycle
  } ssr_sts_t;

endpackage

`default_nettype wire

>>> design/ssr_in_if.sv
// Input channel of the sorted segment reduce block: valid/ready plus one item.
// Depends on ssr_pkg for the field widths.
`default_nettype none

interface ssr_in_if
  import ssr_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic        [ID_W-1:0]    segment_id;
  logic                      last;

  modport source (output valid, output value, output segment_id, output last, input ready);
  modport sink   (input valid, input value, input segment_id, input last, output ready);
endinterface

`default_nettype wire

>>> design/ssr_out_if.sv
// Output channel of the sorted segment reduce block: valid/ready plus one result.
// Depends on ssr_pkg for the field widths.
`default_nettype none

interface ssr_out_if
  import ssr_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic        [ID_W-1:0]    out_segment;
  logic signed [VALUE_W-1:0] result_value;
  logic                      out_last;

  modport source (output valid, output out_segment, output result_value, output out_last,
                  input ready);
  modport sink   (input valid, input out_segment, input result_value, input out_last,
                  output ready);
endinterface

`default_nettype wire

>>> design/ssr_ctrl.sv
// Controller of the sorted segment reduce block: sequences accept, fold, report.
// Depends on ssr_pkg for the command and status structs.
`default_nettype none

module ssr_ctrl
  import ssr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ssr_sts_t sts,
  output ssr_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FOLD,
    S_START,
    S_AFTER,
    S_REPORT,
    S_DIV
  } state_t;

  state_t state;
  state_t state_next;
  logic   rep_last;       // report in flight is the one for a last item
  logic   rep_last_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    rep_last_next = rep_last;
    cmd           = '0;
    cmd.out_last  = rep_last;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.match) begin
          state_next = S_FOLD;
        end else if (sts.run_open) begin
          rep_last_next = 1'b0;
          state_next    = S_REPORT;
        end else begin
          state_next = S_START;
        end
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = S_AFTER;
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_AFTER;
      end
      S_AFTER: begin
        if (sts.item_last) begin
          rep_last_next = 1'b1;
          state_next    = S_REPORT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_REPORT: begin
        if (sts.is_mean) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = rep_last;
          state_next   = rep_last ? S_IDLE : S_START;
        end
      end
      S_DIV: begin
        if (!sts.div_done) begin
          cmd.div_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = rep_last;
          state_next   = rep_last ? S_IDLE : S_START;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rep_last <= 1'b0;
    end else begin
      state    <= state_next;
      rep_last <= rep_last_next;
    end
  end

endmodule

`default_nettype wire

>>> design/ssr_dp.sv
// Datapath of the sorted segment reduce block: item latch, run state, fold unit,
// bit-serial mean divider and result register. Depends on ssr_pkg and ssr_out_if.
`default_nettype none

module ssr_dp
  import ssr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [MODE_W-1:0]         cfg_wdata,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic [ID_W-1:0]           in_segment_id,
  input  wire logic                      in_last,
  input  wire ssr_cmd_t                  cmd,
  output ssr_sts_t                       sts,
  ssr_out_if.source                      res
);

  logic [MODE_W-1:0]  reduce_mode;

  logic [VALUE_W-1:0] item_value;
  logic [ID_W-1:0]    item_id;
  logic               item_last;

  logic [ID_W-1:0]    open_segment;
  logic [ACC_W-1:0]   run_acc;
  logic [COUNT_W-1:0] run_count;
  logic               run_open;

  logic [COUNT_W-1:0] div_rem;
  logic [ACC_W-1:0]   div_quot;
  logic               div_neg;
  logic [DIV_CNT_W-1:0] div_left;

  logic [ACC_W-1:0]   item_sext;
  logic [VALUE_W-1:0] prod_lo;
  logic [ACC_W-1:0]   acc_next;
  logic [COUNT_W:0]   rem_shift;
  logic [COUNT_W:0]   rem_diff;
  logic [ACC_W-1:0]   quot_signed;
  logic [VALUE_W-1:0] mean_val;
  logic [VALUE_W-1:0] report_val;

  assign item_sext = {{(ACC_W-VALUE_W){item_value[VALUE_W-1]}}, item_value};
  assign prod_lo   = run_acc[VALUE_W-1:0] * item_value;

  always_comb begin
    case (reduce_mode)
      MODE_MIN: begin
        acc_next = ($signed(item_sext) < $signed(run_acc)) ? item_sext : run_acc;
      end
      MODE_SUM, MODE_MEAN: begin
        acc_next = run_acc + item_sext;
      end
      MODE_PROD: begin
        acc_next = {{(ACC_W-VALUE_W){prod_lo[VALUE_W-1]}}, prod_lo};
      end
      default: begin
        acc_next = ($signed(run_acc) < $signed(item_sext)) ? item_sext : run_acc;
      end
    endcase
  end

  // Restoring divide step: shift in the next dividend bit, subtract if it fits.
  assign rem_shift   = {div_rem, div_quot[ACC_W-1]};
  assign rem_diff    = rem_shift - {1'b0, run_count};
  assign quot_signed = div_neg ? (~div_quot + ACC_W'(1)) : div_quot;
  assign mean_val    = (run_count == '0) ? '0 : quot_signed[VALUE_W-1:0];
  assign report_val  = sts.is_mean ? mean_val : run_acc[VALUE_W-1:0];

  assign sts.match     = run_open && ((item_id & SEG_MASK) == open_segment);
  assign sts.run_open  = run_open;
  assign sts.item_last = item_last;
  assign sts.is_mean   = (reduce_mode == MODE_MEAN);
  assign sts.div_done  = (div_left == '0);
  assign sts.out_free  = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_mode <= MODE_MAX;
    end else if (cfg_we) begin
      reduce_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_value <= in_value;
      item_id    <= in_segment_id & SEG_MASK;
      item_last  <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_segment <= '0;
      run_acc      <= '0;
      run_count    <= '0;
      run_open     <= 1'b0;
    end else if (cmd.clear) begin
      open_segment <= '0;
      run_acc      <= '0;
      run_count    <= '0;
      run_open     <= 1'b0;
    end else if (cmd.start) begin
      open_segment <= item_id;
      run_acc      <= item_sext;
      run_count    <= COUNT_W'(1);
      run_open     <= 1'b1;
    end else if (cmd.fold) begin
      run_acc   <= acc_next;
      run_count <= run_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_left <= '0;
    end else if (cmd.div_init) begin
      div_left <= DIV_CNT_W'(DIV_STEPS);
    end else if (cmd.div_step) begin
      div_left <= div_left - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_neg  <= run_acc[ACC_W-1];
      div_quot <= run_acc[ACC_W-1] ? (~run_acc + ACC_W'(1)) : run_acc;
      div_rem  <= '0;
    end else if (cmd.div_step) begin
      if (!rem_diff[COUNT_W]) begin
        div_rem  <= rem_diff[COUNT_W-1:0];
        div_quot <= {div_quot[ACC_W-2:0], 1'b1};
      end else begin
        div_rem  <= rem_shift[COUNT_W-1:0];
        div_quot <= {div_quot[ACC_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.out_segment  <= open_segment;
      res.result_value <= report_val;
      res.out_last     <= cmd.out_last;
    end
  end

endmodule

`default_nettype wire

>>> design/sorted_segment_reduce.sv
// Top level of the sorted segment reduce block: controller plus datapath.
// Depends on ssr_pkg, ssr_in_if, ssr_out_if, ssr_ctrl and ssr_dp.
//
// Usage:
//   items_in carries one item per handshake: a signed 32-bit value, its segment
//   id and a last flag. Ids are expected sorted; a change of id closes the open
//   run and sends its reduction on results_out. An item with last set closes the
//   stream: its run goes out with out_last high and the run state is cleared.
//   cfg_we/cfg_wdata write the reduction code (max, min, sum, mean, product);
//   write it only while the block is idle.
// Timing:
//   Items are taken one at a time. An item that only folds or opens a run
//   passes through capture, id compare, fold or open and a last check before
//   the next ready. Each result it causes adds a report step, and in mean mode
//   a divide of the 64-bit sum by a divider that makes one quotient bit per cycle.
//   A result appears on results_out the cycle after it is formed.
// Reset: rst (synchronous, active high) empties the run, drops any waiting
//   result and sets the code to max.
// Stall: the result register holds a result until it is taken; a new item may
//   be accepted meanwhile, but the next result waits until the register frees.
`default_nettype none

module sorted_segment_reduce
  import ssr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [MODE_W-1:0] cfg_wdata,
  ssr_in_if.sink                 items_in,
  ssr_out_if.source              results_out
);

  ssr_cmd_t cmd;
  ssr_sts_t sts;
  logic     in_ready;

  assign items_in.ready = in_ready;

  // Sequence each item: capture, compare ids, fold or open, report as needed.
  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items_in.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold run state, fold arithmetic, the mean divider and the result register.
  ssr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_value      (items_in.value),
    .in_segment_id (items_in.segment_id),
    .in_last       (items_in.last),
    .cmd           (cmd),
    .sts           (sts),
    .res           (results_out)
  );

  // Never overwrite a result that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result register loaded while a result waits");

  // Fold only into an open run.
  a_fold_open: assert property (@(posedge clk) disable iff (rst)
    cmd.fold |-> sts.run_open)
    else $error("fold issued with no open run");

  // Divider steps stop once all quotient bits are made.
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !sts.div_done)
    else $error("divider stepped past its last bit");

  // One item at a time: ready drops right after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (items_in.valid && items_in.ready) |=> !items_in.ready)
    else $error("second item accepted while one is in work");

endmodule

`default_nettype wire

>>> tb/tb_sorted_segment_reduce.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_segment_reduce: directed table, then random streams.
// Depends on ssr_pkg, ssr_in_if, ssr_out_if and the sorted_segment_reduce RTL.

module tb_sorted_segment_reduce;
  import ssr_pkg::*;

  // One result as it leaves the block.
  typedef struct packed {
    logic [ID_W-1:0]    seg;
    logic [VALUE_W-1:0] val;
    logic               lst;
  } seg_result_t;

  // One row of the directed table: either a mode write or one item. Rows with
  // typed set carry their results written out by hand; the rest use the predictor.
  typedef struct packed {
    bit                 is_cfg;
    logic [MODE_W-1:0]  mode;
    bit                 typed;
    logic [1:0]         n_typed;
    logic [VALUE_W-1:0] val;
    logic [ID_W-1:0]    id;
    logic               lst;
    seg_result_t        t0;
    seg_result_t        t1;
  } stim_row_t;

  // Codes 5 to 7 are unassigned and fold like max.
  localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD7   = 3'd7;

  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [ID_W-1:0]    ID_TOP  = 16'hffff;

  localparam seg_result_t NO_RESULT = '{16'd0, 32'd0, 1'b0};

  // Worst result formation is two mean divisions back to back.
  localparam int DRAIN_CYCLES  = 150;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_ITEMS  = 1500;

  localparam int NUM_ROWS = 31;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // max after reset: extremes fold within one run, then a new id closes it
    '{1'b0, MODE_MAX, 1'b1, 2'd0, 32'd5,        16'd3, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, VAL_MIN,      16'd3, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, VAL_MAX,      16'd3, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd1, 32'd7,        16'd4, 1'b0,
      '{16'd3, VAL_MAX, 1'b0}, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd1, 32'hffff_ffff, 16'd4, 1'b1,
      '{16'd4, 32'd7, 1'b1}, NO_RESULT},
    // id 0 right after a stream end must open a fresh run, not fold into the cleared one
    '{1'b0, MODE_MAX, 1'b1, 2'd1, VAL_MIN,      16'd0, 1'b1,
      '{16'd0, VAL_MIN, 1'b1}, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd1, VAL_MAX,      ID_TOP, 1'b1,
      '{ID_TOP, VAL_MAX, 1'b1}, NO_RESULT},
    // min, with a falling id on the last item: two results from one item
    '{1'b1, MODE_MIN, 1'b0, 2'd0, 32'd0,        16'd0, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, 32'd10,       16'd100, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, VAL_MIN,      16'd100, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd2, VAL_MAX,      16'd99, 1'b1,
      '{16'd100, VAL_MIN, 1'b0}, '{16'd99, VAL_MAX, 1'b1}},
    // sum wraps at 32 bits
    '{1'b1, MODE_SUM, 1'b0, 2'd0, 32'd0,        16'd0, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, VAL_MAX,      16'd5, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd1, 32'd1,        16'd5, 1'b1,
      '{16'd5, VAL_MIN, 1'b1}, NO_RESULT},
    // mean truncates toward zero and keeps the full 64-bit sum
    '{1'b1, MODE_MEAN, 1'b0, 2'd0, 32'd0,       16'd0, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, 32'hffff_fff9, 16'd6, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd1, 32'd2,        16'd6, 1'b1,
      '{16'd6, 32'hffff_fffe, 1'b1}, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, VAL_MAX,      16'd7, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, VAL_MAX,      16'd7, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd1, VAL_MAX,      16'd7, 1'b1,
      '{16'd7, VAL_MAX, 1'b1}, NO_RESULT},
    // product wraps to zero at 2^32
    '{1'b1, MODE_PROD, 1'b0, 2'd0, 32'd0,       16'd0, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, 32'h0001_0000, 16'd8, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, 32'h0001_0000, 16'd8, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd2, 32'd3,        16'd9, 1'b1,
      '{16'd8, 32'd0, 1'b0}, '{16'd9, 32'd3, 1'b1}},
    // unassigned code behaves as max
    '{1'b1, MODE_RSVD7, 1'b0, 2'd0, 32'd0,      16'd0, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, 32'hffff_fffb, 16'd10, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd1, 32'hffff_fffd, 16'd10, 1'b1,
      '{16'd10, 32'hffff_fffd, 1'b1}, NO_RESULT},
    // mode switched while a run is open: the sum accumulator is then compared as max
    '{1'b1, MODE_SUM, 1'b0, 2'd0, 32'd0,        16'd0, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b1, 2'd0, 32'd100,      16'd11, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b1, MODE_MAX, 1'b0, 2'd0, 32'd0,        16'd0, 1'b0, NO_RESULT, NO_RESULT},
    '{1'b0, MODE_MAX, 1'b0, 2'd0, 32'd50,       16'd11, 1'b1, NO_RESULT, NO_RESULT}
  };

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_wdata;

  ssr_in_if  items_bus ();
  ssr_out_if results_bus ();

  sorted_segment_reduce u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .items_in    (items_bus),
    .results_out (results_bus)
  );

  // Predictor state: a private copy of the mode register and the open run.
  logic [MODE_W-1:0]  mode_q;
  logic [ID_W-1:0]    run_seg;
  logic [ACC_W-1:0]   run_acc;
  logic [COUNT_W-1:0] run_cnt;
  bit                 run_live;

  seg_result_t pending_results[$];
  int          mismatch_cnt;
  int          random_items;
  int          quiet_cycles;
  bit          calm;   // phase with no idling on either side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length for both sides: mostly none or short, now and then long.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Value mix: full range, small signed, hard extremes, mid-size signed.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      2: return VALUE_W'($signed($urandom_range(0, 16)) - 8);
      3: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 32'd0;
          default: return 32'hffff_ffff;
        endcase
      end
      4: return VALUE_W'($signed($urandom_range(0, 65535)) - 32768);
      default: return $urandom;
    endcase
  endfunction

  // Reported value of the open run under the current mode. Sum and the
  // running max/min/product all report the low word of the accumulator.
  function automatic logic [VALUE_W-1:0] segment_report();
    longint sum_s;
    longint cnt_s;
    longint quo;
    if (mode_q == MODE_MEAN) begin
      if (run_cnt == '0) return '0;
      sum_s = run_acc;
      cnt_s = {32'd0, run_cnt};
      quo   = sum_s / cnt_s;   // signed divide truncates toward zero
      return quo[VALUE_W-1:0];
    end
    return run_acc[VALUE_W-1:0];
  endfunction

  // Advance the predicted run by one accepted item; hand back up to two results.
  task automatic reduce_step(input logic [VALUE_W-1:0] val, input logic [ID_W-1:0] raw_id,
                             input logic lst, output int n,
                             output seg_result_t r0, output seg_result_t r1);
    logic [ACC_W-1:0]   wide;
    logic [ID_W-1:0]    id;
    logic [VALUE_W-1:0] prod;
    seg_result_t        closing;
    wide = {{(ACC_W-VALUE_W){val[VALUE_W-1]}}, val};
    id   = raw_id & SEG_MASK;
    n    = 0;
    r0   = NO_RESULT;
    r1   = NO_RESULT;
    if (run_live && id == run_seg) begin
      case (mode_q)
        MODE_MIN: if ($signed(wide) < $signed(run_acc)) run_acc = wide;
        MODE_SUM, MODE_MEAN: run_acc = run_acc + wide;
        MODE_PROD: begin
          prod    = run_acc[VALUE_W-1:0] * wide[VALUE_W-1:0];
          run_acc = {{(ACC_W-VALUE_W){prod[VALUE_W-1]}}, prod};
        end
        default: if ($signed(run_acc) < $signed(wide)) run_acc = wide;
      endcase
      run_cnt = run_cnt + 1'b1;
    end else begin
      // any other id, higher or lower, closes the open run first
      if (run_live) begin
        r0 = '{run_seg, segment_report(), 1'b0};
        n  = 1;
      end
      run_seg  = id;
      run_acc  = wide;
      run_cnt  = 1;
      run_live = 1'b1;
    end
    if (lst) begin
      closing = '{run_seg, segment_report(), 1'b1};
      if (n == 0) r0 = closing;
      else r1 = closing;
      n++;
      run_seg  = '0;
      run_acc  = '0;
      run_cnt  = '0;
      run_live = 1'b0;
    end
  endtask

  // Present one item, hold it until taken, then queue what it should produce.
  // Valid stays high after the accept so a back-to-back item needs no toggle.
  task automatic send_item(input logic [VALUE_W-1:0] val, input logic [ID_W-1:0] id,
                           input logic lst, input bit typed, input int n_typed,
                           input seg_result_t t0, input seg_result_t t1);
    int          gap;
    int          n;
    seg_result_t p0;
    seg_result_t p1;
    gap = gap_cycles();
    if (gap > 0) begin
      items_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_bus.valid      <= 1'b1;
    items_bus.value      <= val;
    items_bus.segment_id <= id;
    items_bus.last       <= lst;
    @(posedge clk);
    while (!items_bus.ready) @(posedge clk);
    reduce_step(val, id, lst, n, p0, p1);
    if (typed) begin
      n  = n_typed;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) pending_results.push_back(p0);
    if (n > 1) pending_results.push_back(p1);
  endtask

  // Drop valid in the step of the last accept, let every result out, then
  // give the back end time to finish, and only then write the mode.
  task automatic write_mode(input logic [MODE_W-1:0] mode);
    items_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wdata <= mode;
    cfg_we    <= 1'b1;
    @(posedge clk);
    mode_q = mode;
    cfg_we <= 1'b0;
  endtask

  // One random stream under a random mode. Mostly sorted runs with random
  // content; a few stray ids and early last flags break the pattern.
  task automatic random_phase();
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    id;
    logic [ID_W-1:0]    item_id;
    logic [VALUE_W-1:0] val;
    logic               lst;
    bit                 close_stream;
    int                 nseg;
    int                 len;
    if ($urandom_range(0, 4) == 0) mode = MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD7));
    else mode = MODE_W'($urandom_range(MODE_MAX, MODE_PROD));
    write_mode(mode);
    calm = ($urandom_range(0, 5) == 0);
    // leave the last run open now and then, so the next mode applies mid-run
    close_stream = ($urandom_range(0, 6) != 0);
    nseg = $urandom_range(1, 12);
    id   = ID_W'($urandom_range(0, 65535));
    for (int s = 0; s < nseg; s++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        val     = pick_value();
        item_id = ($urandom_range(0, 19) == 0) ? ID_W'($urandom_range(0, 65535)) : id;
        lst     = (s == nseg - 1 && k == len - 1) ? close_stream
                                                  : ($urandom_range(0, 39) == 0);
        send_item(val, item_id, lst, 1'b0, 0, NO_RESULT, NO_RESULT);
        random_items++;
      end
      // step to the next id: usually adjacent, sometimes a far jump (may wrap)
      if ($urandom_range(0, 7) == 0) id = id + ID_W'($urandom_range(4, 20000));
      else id = id + ID_W'($urandom_range(1, 3));
    end
  endtask

  // Result side: random back-pressure, with calm phases keeping ready high.
  initial begin
    results_bus.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      int stall;
      results_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      stall = gap_cycles();
      if (stall > 0) begin
        results_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare each taken result against the oldest expectation, field by field.
  always @(posedge clk) begin
    seg_result_t want;
    if (!rst && results_bus.valid && results_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result seg=%0d value=%0d last=%0b", $realtime,
                 results_bus.out_segment, $signed(results_bus.result_value),
                 results_bus.out_last);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (results_bus.out_segment !== want.seg) begin
          $display("%0t: out_segment expected %0d got %0d", $realtime, want.seg,
                   results_bus.out_segment);
          mismatch_cnt++;
        end
        if (results_bus.result_value !== want.val) begin
          $display("%0t: result_value (seg %0d) expected %0d got %0d", $realtime, want.seg,
                   $signed(want.val), $signed(results_bus.result_value));
          mismatch_cnt++;
        end
        if (results_bus.out_last !== want.lst) begin
          $display("%0t: out_last (seg %0d) expected %0b got %0b", $realtime, want.seg,
                   want.lst, results_bus.out_last);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side means a hang.
  always @(posedge clk) begin
    if ((items_bus.valid && items_bus.ready) || (results_bus.valid && results_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
      $display("sorted_segment_reduce verification failed");
      $finish;
    end
  end

  initial begin
    items_bus.valid      <= 1'b0;
    items_bus.value      <= '0;
    items_bus.segment_id <= '0;
    items_bus.last       <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= MODE_MAX;
    mode_q       = MODE_MAX;
    run_seg      = '0;
    run_acc      = '0;
    run_cnt      = '0;
    run_live     = 1'b0;
    mismatch_cnt = 0;
    random_items = 0;
    quiet_cycles = 0;
    calm         = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: mode writes wait for idle, items go through the predictor.
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].is_cfg)
        write_mode(DIRECTED[i].mode);
      else
        send_item(DIRECTED[i].val, DIRECTED[i].id, DIRECTED[i].lst, DIRECTED[i].typed,
                  DIRECTED[i].n_typed, DIRECTED[i].t0, DIRECTED[i].t1);
    end

    while (random_items < RANDOM_ITEMS) random_phase();

    // Drain: release valid, let every result arrive, then watch for strays.
    items_bus.valid <= 1'b0;
    calm = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("sorted_segment_reduce verification clean");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $realtime,
                 pending_results.size());
      $display("sorted_segment_reduce verification failed");
    end
    $finish;
  end

endmodule
